### rtl/nfa_regex_matcher_unit_defines.svh
// Assertion macros for the NFA matcher.
`ifndef NFA_REGEX_MATCHER_UNIT_DEFINES_SVH
`define NFA_REGEX_MATCHER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define NRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define NRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/nrm_pkg.sv
package nrm_pkg;

    localparam logic [1:0] OP_LOAD_TRANS = 2'd0;
    localparam logic [1:0] OP_LOAD_CLASS = 2'd1;
    localparam logic [1:0] OP_START      = 2'd2;
    localparam logic [1:0] OP_SYMBOL     = 2'd3;

    localparam logic [1:0] KIND_EPS   = 2'd0;
    localparam logic [1:0] KIND_LIT   = 2'd1;
    localparam logic [1:0] KIND_CLASS = 2'd2;

    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_ACCEPT = 2'd1;
    localparam logic [1:0] CFG_COUNT  = 2'd2;

    typedef struct packed {
        logic [4:0] from_state;
        logic [4:0] to_state;
        logic [1:0] kind;
        logic [7:0] literal;
        logic [3:0] class_id;
    } trans_t;

endpackage

### rtl/nfa_regex_matcher_unit.sv
// NFA matcher. Load transitions (opcode 0) and class bitmap quarters (opcode 1),
// then send a start item (2) and symbol items (3). Every item returns one
// result beat: accepted, dead and the active state set after the item. The
// transition memory is scanned one entry at a time, each entry first addressed
// and then evaluated. A class transition that leaves an active state during the
// symbol move adds a step for the class memory read. N is the effective
// transition count. Closure runs in passes over the table; the last pass adds
// no state. A start with N zero, and a symbol with N zero or an empty set, go
// straight to the result with no scan. One item is in flight at a time. The
// finished result sits in an output register while the next item is accepted.
`include "nfa_regex_matcher_unit_defines.svh"

module nfa_regex_matcher_unit #(
    parameter int NUM_STATES      = 32,
    parameter int NUM_TRANSITIONS = 64,
    parameter int NUM_CLASSES     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [5:0]  entry_index,
    input  logic [4:0]  from_state,
    input  logic [4:0]  to_state,
    input  logic [1:0]  match_kind,
    input  logic [7:0]  literal,
    input  logic [3:0]  class_id,
    input  logic [1:0]  class_word_sel,
    input  logic [63:0] class_word,
    input  logic [7:0]  symbol,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        dead,
    output logic [31:0] active_set
);

    localparam int TW  = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
    localparam int CNW = $clog2(NUM_TRANSITIONS + 1);
    localparam int CW  = $clog2(NUM_CLASSES * 4);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_CLS   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    nrm_pkg::trans_t tmem [NUM_TRANSITIONS];
    logic [63:0]     cmem [NUM_CLASSES * 4];
    nrm_pkg::trans_t t_rd;
    logic [63:0]     c_rd;

    logic [4:0] start_reg, accept_reg;
    logic [6:0] count_reg;
    logic [2:0] st_reg;
    logic [CNW-1:0] idx_reg;
    logic       move_reg, grew_reg;
    logic [7:0] sym_reg;
    logic [31:0] set_reg, nxt_reg;
    logic        ov_reg;
    logic        acc_reg, dead_reg;
    logic [31:0] out_reg;

    logic [CNW-1:0] n_eff;
    logic           take;
    logic           last;
    logic [31:0]    smask;

    assign smask = (NUM_STATES >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_STATES) - 32'd1);
    assign n_eff = (count_reg > 7'(NUM_TRANSITIONS)) ? CNW'(NUM_TRANSITIONS)
                                                      : CNW'(count_reg);
    assign take = in_valid && !in_stall;
    assign in_stall = (st_reg != S_IDLE);
    assign last = (idx_reg + CNW'(1)) >= n_eff;

    function automatic logic [31:0] sbit(input logic [4:0] s);
        sbit = (32'(s) < 32'(NUM_STATES)) ? (32'd1 << s) : 32'd0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            accept_reg <= 5'd1;
            count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nrm_pkg::CFG_START:  start_reg  <= cfg_data[4:0];
                nrm_pkg::CFG_ACCEPT: accept_reg <= cfg_data[4:0];
                nrm_pkg::CFG_COUNT:  count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (take && opcode == nrm_pkg::OP_LOAD_TRANS && 32'(entry_index) < 32'(NUM_TRANSITIONS))
            tmem[entry_index[TW-1:0]] <= '{from_state, to_state, match_kind, literal, class_id};
        if (take && opcode == nrm_pkg::OP_LOAD_CLASS && 32'(entry_index) < 32'(NUM_CLASSES))
            cmem[CW'({entry_index, class_word_sel})] <= class_word;
        t_rd <= tmem[idx_reg[TW-1:0]];
        c_rd <= cmem[CW'({t_rd.class_id, sym_reg[7:6]})];
    end

    logic [31:0] set_upd;
    logic        eps_hit;
    logic        lit_hit;
    always_comb
    begin
        eps_hit = (t_rd.kind == nrm_pkg::KIND_EPS) && |(set_reg & sbit(t_rd.from_state))
                  && |(sbit(t_rd.to_state) & ~set_reg);
        lit_hit = (t_rd.kind == nrm_pkg::KIND_LIT) && (t_rd.literal == sym_reg)
                  && |(set_reg & sbit(t_rd.from_state));
        set_upd = set_reg | sbit(t_rd.to_state);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            idx_reg  <= '0;
            move_reg <= 1'b0;
            grew_reg <= 1'b0;
            sym_reg  <= '0;
            set_reg  <= '0;
            nxt_reg  <= '0;
            ov_reg   <= 1'b0;
            acc_reg  <= 1'b0;
            dead_reg <= 1'b1;
            out_reg  <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall && st_reg != S_DONE)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    idx_reg  <= '0;
                    grew_reg <= 1'b0;
                    sym_reg  <= symbol;
                    if (take)
                    begin
                        if (opcode == nrm_pkg::OP_START)
                        begin
                            set_reg  <= sbit(start_reg);
                            move_reg <= 1'b0;
                            st_reg   <= (n_eff == '0) ? S_DONE : S_RD;
                        end
                        else if (opcode == nrm_pkg::OP_SYMBOL)
                        begin
                            nxt_reg  <= '0;
                            move_reg <= 1'b1;
                            st_reg   <= (n_eff == '0 || set_reg == '0) ? S_DONE : S_RD;
                            if (n_eff == '0)
                                set_reg <= '0;
                        end
                        else
                            st_reg <= S_DONE;
                    end
                end
                S_RD: st_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (move_reg && t_rd.kind == nrm_pkg::KIND_CLASS
                        && |(set_reg & sbit(t_rd.from_state))
                        && 32'(t_rd.class_id) < 32'(NUM_CLASSES))
                        st_reg <= S_CLS;
                    else
                    begin
                        if (move_reg && lit_hit)
                            nxt_reg <= nxt_reg | sbit(t_rd.to_state);
                        if (!move_reg && eps_hit)
                            set_reg <= set_upd;
                        idx_reg <= last ? '0 : idx_reg + CNW'(1);
                        if (last)
                        begin
                            grew_reg <= 1'b0;
                            st_reg   <= (!move_reg && !(grew_reg || eps_hit)) ? S_DONE : S_RD;
                            if (move_reg)
                            begin
                                move_reg <= 1'b0;
                                set_reg  <= nxt_reg | (lit_hit ? sbit(t_rd.to_state) : '0);
                            end
                        end
                        else
                        begin
                            st_reg <= S_RD;
                            if (!move_reg && eps_hit)
                                grew_reg <= 1'b1;
                        end
                    end
                end
                S_CLS:
                begin
                    if (c_rd[sym_reg[5:0]])
                        nxt_reg <= nxt_reg | sbit(t_rd.to_state);
                    idx_reg <= last ? '0 : idx_reg + CNW'(1);
                    st_reg  <= S_RD;
                    if (last)
                    begin
                        move_reg <= 1'b0;
                        set_reg  <= nxt_reg | (c_rd[sym_reg[5:0]] ? sbit(t_rd.to_state) : '0);
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg   <= 1'b1;
                        out_reg  <= set_reg & smask;
                        acc_reg  <= |(set_reg & sbit(accept_reg));
                        dead_reg <= (set_reg & smask) == '0;
                        st_reg   <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = ov_reg;
    assign accepted   = acc_reg;
    assign dead       = dead_reg;
    assign active_set = out_reg;

    `NRM_ASSERT_IMPL(a_busy_stall, clk, rst_n, st_reg != S_IDLE, in_stall)
    `NRM_ASSERT_IMPL(a_dead_flag, clk, rst_n, ov_reg, dead_reg == (out_reg == '0))
    `NRM_ASSERT_NEXT(a_done_out, clk, rst_n, st_reg == S_DONE && !(ov_reg && out_stall),
                     ov_reg && st_reg == S_IDLE)
    `NRM_ASSERT_IMPL(a_acc_set, clk, rst_n, ov_reg && acc_reg, !dead_reg)

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE    = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  idx;
        logic [4:0]  src;
        logic [4:0]  dst;
        logic [1:0]  kind;
        logic [7:0]  lit;
        logic [3:0]  cls;
        logic [1:0]  sel;
        logic [63:0] word;
        logic [7:0]  sym;
    } beat_t;

    typedef struct {
        logic        acc;
        logic        dd;
        logic [31:0] set;
    } state_rpt_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [5:0]  entry_index = '0;
    logic [4:0]  from_state = '0;
    logic [4:0]  to_state = '0;
    logic [1:0]  match_kind = '0;
    logic [7:0]  literal = '0;
    logic [3:0]  class_id = '0;
    logic [1:0]  class_word_sel = '0;
    logic [63:0] class_word = '0;
    logic [7:0]  symbol = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        accepted;
    logic        dead;
    logic [31:0] active_set;

    nfa_regex_matcher_unit dut (.*);

    always #6 clk = ~clk;

    nrm_pkg::trans_t nfa_edges [64];
    logic [63:0] class_bits [64];
    logic [31:0] live_set;
    logic [4:0]  start_reg;
    logic [4:0]  accept_reg;
    logic [6:0]  count_reg;

    beat_t       pending_beats [$];
    state_rpt_t  expected_sets [$];
    int          mismatch_count = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          quiet_out = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int edge_limit();
        return (count_reg > 7'd64) ? 64 : int'(count_reg);
    endfunction

    function automatic logic [31:0] eps_closure(logic [31:0] s);
        bit grew;
        int n;
        n = edge_limit();
        grew = 1;
        while (grew) begin
            grew = 0;
            for (int i = 0; i < n; i++)
                if (nfa_edges[i].kind == nrm_pkg::KIND_EPS && s[nfa_edges[i].from_state]
                    && !s[nfa_edges[i].to_state]) begin
                    s[nfa_edges[i].to_state] = 1'b1;
                    grew = 1;
                end
        end
        return s;
    endfunction

    function automatic logic [31:0] step_on(logic [31:0] s, logic [7:0] b);
        logic [31:0] nx;
        nrm_pkg::trans_t e;
        bit hit;
        nx = '0;
        for (int i = 0; i < edge_limit(); i++) begin
            e = nfa_edges[i];
            hit = 0;
            if (s[e.from_state]) begin
                if (e.kind == nrm_pkg::KIND_LIT) hit = (e.literal == b);
                else if (e.kind == nrm_pkg::KIND_CLASS)
                    hit = class_bits[{e.class_id, b[7:6]}][b[5:0]];
            end
            if (hit) nx[e.to_state] = 1'b1;
        end
        return nx;
    endfunction

    function automatic void predict_match(beat_t b);
        state_rpt_t r;
        case (b.op)
            nrm_pkg::OP_LOAD_TRANS:
                nfa_edges[b.idx] = '{b.src, b.dst, b.kind, b.lit, b.cls};
            nrm_pkg::OP_LOAD_CLASS:
                if (b.idx < 6'd16) class_bits[{b.idx[3:0], b.sel}] = b.word;
            nrm_pkg::OP_START: live_set = eps_closure(32'd1 << start_reg);
            default: live_set = eps_closure(step_on(live_set, b.sym));
        endcase
        r.acc = live_set[accept_reg];
        r.dd = (live_set == '0);
        r.set = live_set;
        expected_sets = {expected_sets, r};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if ((!in_valid || !in_stall) && pending_beats.size() > 0 && in_gap == 0) begin
            beat_t b;
            b = pending_beats.pop_front();
            predict_match(b);
            opcode <= b.op;
            entry_index <= b.idx;
            from_state <= b.src;
            to_state <= b.dst;
            match_kind <= b.kind;
            literal <= b.lit;
            class_id <= b.cls;
            class_word_sel <= b.sel;
            class_word <= b.word;
            symbol <= b.sym;
            in_valid <= 1'b1;
            in_gap = gap_len();
        end
        else begin
            if (in_valid && !in_stall)
                in_valid <= 1'b0;
            if ((!in_valid || !in_stall) && in_gap > 0)
                in_gap--;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall) begin
            if (expected_sets.size() == 0)
                report_mismatch("unexpected beat", active_set, '0);
            else begin
                state_rpt_t r;
                r = expected_sets.pop_front();
                if (accepted !== r.acc)
                    report_mismatch("accepted", 32'(accepted), 32'(r.acc));
                if (dead !== r.dd) report_mismatch("dead", 32'(dead), 32'(r.dd));
                if (active_set !== r.set) report_mismatch("active_set", active_set, r.set);
            end
        end
        if (quiet_out)
            out_stall <= 1'b0;
        else if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) out_gap = gap_len();
        end
    end

    task automatic queue_edge(int slot, int s, int d, logic [1:0] k, int l, int c);
        beat_t b;
        b = '{nrm_pkg::OP_LOAD_TRANS, slot[5:0], s[4:0], d[4:0], k, l[7:0], c[3:0],
              2'($urandom()), {$urandom(), $urandom()}, 8'($urandom())};
        pending_beats = {pending_beats, b};
    endtask

    task automatic queue_class(int cls, int sel, logic [63:0] w);
        beat_t b;
        b = '{nrm_pkg::OP_LOAD_CLASS, cls[5:0], 5'($urandom()), 5'($urandom()),
              2'($urandom()), 8'($urandom()), 4'($urandom()), sel[1:0], w,
              8'($urandom())};
        pending_beats = {pending_beats, b};
    endtask

    task automatic queue_run(logic [1:0] op, int sy);
        beat_t b;
        b = '{op, 6'($urandom()), 5'($urandom()), 5'($urandom()), 2'($urandom()),
              8'($urandom()), 4'($urandom()), 2'($urandom()), {$urandom(), $urandom()},
              sy[7:0]};
        pending_beats = {pending_beats, b};
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || expected_sets.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] i, int v);
        cfg_we <= 1'b1;
        cfg_index <= i;
        cfg_data <= v[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (i == nrm_pkg::CFG_START) start_reg = v[4:0];
        else if (i == nrm_pkg::CFG_ACCEPT) accept_reg = v[4:0];
        else if (i == nrm_pkg::CFG_COUNT) count_reg = v[6:0];
        @(posedge clk);
    endtask

    initial
    begin
        int n;
        live_set = '0;
        start_reg = 0;
        accept_reg = 1;
        count_reg = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tables fully written before any run
        for (int c = 0; c < 16; c++)
            for (int s = 0; s < 4; s++)
                queue_class(c, s, (c == 0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                           : {$urandom(), $urandom()});
        queue_class(63, 3, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 64; i++)
            queue_edge(i, i % 32, (i + 1) % 32, KIND_UNUSED, 0, 0);
        queue_run(nrm_pkg::OP_SYMBOL, 0);
        queue_edge(0, 0, 1, nrm_pkg::KIND_EPS, 0, 0);
        queue_edge(1, 1, 2, nrm_pkg::KIND_LIT, 8'hFF, 0);
        queue_edge(2, 2, 31, nrm_pkg::KIND_CLASS, 0, 0);
        queue_edge(3, 31, 0, nrm_pkg::KIND_EPS, 0, 15);
        queue_edge(4, 2, 3, KIND_UNUSED, 0, 0);
        drain();
        write_reg(nrm_pkg::CFG_COUNT, 127);
        write_reg(nrm_pkg::CFG_ACCEPT, 31);
        write_reg(nrm_pkg::CFG_START, 0);
        queue_run(nrm_pkg::OP_START, 0);
        queue_run(nrm_pkg::OP_SYMBOL, 255);
        queue_run(nrm_pkg::OP_SYMBOL, 7);
        queue_run(nrm_pkg::OP_SYMBOL, 0);
        queue_run(nrm_pkg::OP_SYMBOL, 1);
        queue_run(nrm_pkg::OP_SYMBOL, 1);
        drain();
        write_reg(CFG_NONE, 5);
        write_reg(nrm_pkg::CFG_START, 31);
        write_reg(nrm_pkg::CFG_ACCEPT, 0);
        write_reg(nrm_pkg::CFG_COUNT, 0);
        queue_run(nrm_pkg::OP_START, 0);
        queue_run(nrm_pkg::OP_SYMBOL, 128);
        drain();

        // random: small NFAs, load then run strings
        n = 0;
        while (n < 1200) begin
            int cnt;
            cnt = $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) cnt = 64;
            for (int i = 0; i < cnt; i++) begin
                int k;
                logic [1:0] kd;
                k = $urandom_range(0, 9);
                kd = (k < 3) ? nrm_pkg::KIND_EPS : (k < 7) ? nrm_pkg::KIND_LIT
                   : (k < 9) ? nrm_pkg::KIND_CLASS : KIND_UNUSED;
                queue_edge(i, $urandom_range(0, 7), $urandom_range(0, 7), kd,
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(97, 100),
                           $urandom_range(0, 15));
                n++;
            end
            for (int i = 0; i < $urandom_range(0, 3); i++) begin
                queue_class($urandom_range(0, 63), $urandom_range(0, 3),
                            {$urandom(), $urandom()});
                n++;
            end
            drain();
            write_reg(nrm_pkg::CFG_START, $urandom_range(0, 7));
            write_reg(nrm_pkg::CFG_ACCEPT, $urandom_range(0, 7));
            write_reg(nrm_pkg::CFG_COUNT,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : cnt);
            for (int r = 0; r < 3; r++) begin
                queue_run(nrm_pkg::OP_START, 0);
                n++;
                for (int j = 0; j < $urandom_range(1, 8); j++) begin
                    queue_run(nrm_pkg::OP_SYMBOL, $urandom_range(0, 3) == 0
                              ? $urandom_range(0, 255) : $urandom_range(97, 100));
                    n++;
                end
            end
            quiet_out = ($urandom_range(0, 4) == 0);
            drain();
            quiet_out = 0;
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("FAIL");
        $finish;
    end
endmodule
